@@ rtl/pnz_pkg.sv @@
// ----------------------------------------------------------------------------
// pnz_pkg: shared types and constants for the 3-D gradient noise pipeline
// Holds the lattice permutation table, the corner hash vector type and the
// pipeline latency seen at the top-level ports.
// ----------------------------------------------------------------------------
package pnz_pkg;

   localparam int LATTICE_SIZE = 256;
   localparam int CELL_BITS    = 8;
   localparam int HASH_BITS    = 4;
   localparam int CORNERS      = 8;

   // input register + three hash/fade stages + five blend stages
   localparam int PIPE_LATENCY = 9;

   localparam logic [15:0] OUT_MAX = 16'hFFFF;

   typedef logic [CELL_BITS-1:0] cell_type;
   typedef logic [HASH_BITS-1:0] hash_type;
   typedef hash_type [CORNERS-1:0] hash_vec_type;

   localparam logic [7:0] PERM_TABLE [LATTICE_SIZE] = '{
      8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,
      8'd194,8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,
      8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,8'd234,8'd75,
      8'd0,8'd26,8'd197,8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,
      8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,8'd174,8'd20,8'd125,8'd136,
      8'd171,8'd168,8'd68,8'd175,8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,
      8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,
      8'd220,8'd105,8'd92,8'd41,8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,
      8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,8'd209,8'd76,8'd132,8'd187,
      8'd208,8'd89,8'd18,8'd169,8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,
      8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,8'd52,8'd217,8'd226,8'd250,
      8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,
      8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,8'd182,8'd189,8'd28,8'd42,
      8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,
      8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,8'd129,8'd22,8'd39,8'd253,
      8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,
      8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,8'd238,8'd210,8'd144,8'd12,
      8'd191,8'd179,8'd162,8'd241,8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,
      8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,8'd184,8'd84,8'd204,8'd176,
      8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,
      8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,8'd128,8'd195,8'd78,8'd66,
      8'd215,8'd61,8'd156,8'd180
   };

   // Look up the permutation; the index wraps to the lattice size
   function automatic cell_type perm(input cell_type idx);
      return PERM_TABLE[idx];
   endfunction

endpackage

@@ rtl/pnz_fade.sv @@
// ----------------------------------------------------------------------------
// pnz_fade: quintic fade curve 6t^5 - 15t^4 + 10t^3
// Three register stages; every product is rounded to nearest, ties upward.
// ----------------------------------------------------------------------------
module pnz_fade #(
   parameter int FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic [FRAC_BITS-1:0]        frac,
   output logic signed [FRAC_BITS+4:0] fade
);

   localparam int QW = FRAC_BITS + 5;
   localparam logic signed [QW-1:0]   Q_ONE  = QW'(1) <<< FRAC_BITS;
   localparam logic signed [2*QW-1:0] P_HALF = (2*QW)'(1) <<< (FRAC_BITS - 1);

   function automatic logic signed [QW-1:0] qmul(input logic signed [QW-1:0] a,
                                                 input logic signed [QW-1:0] b);
      logic signed [2*QW-1:0] p;
      p = a * b + P_HALF;
      return QW'(p >>> FRAC_BITS);
   endfunction

   logic signed [QW-1:0] t0;
   logic signed [QW-1:0] t_a_ff, tt_ff, ti_a_ff;
   logic signed [QW-1:0] t3_ff, ti_b_ff;
   logic signed [QW-1:0] fade_ff;

   assign t0 = QW'(frac);

   // Stage A: t^2 and the inner polynomial t(6t-15)+10
   // Stage B: t^3
   // Stage C: t^3 times the inner polynomial
   always_ff @(posedge clock) begin
      t_a_ff  <= t0;
      tt_ff   <= qmul(t0, t0);
      ti_a_ff <= qmul(t0, QW'(6) * t0 - QW'(15) * Q_ONE) + QW'(10) * Q_ONE;
      t3_ff   <= qmul(tt_ff, t_a_ff);
      ti_b_ff <= ti_a_ff;
      fade_ff <= qmul(t3_ff, ti_b_ff);
   end

   assign fade = fade_ff;

endmodule

@@ rtl/pnz_hash.sv @@
// ----------------------------------------------------------------------------
// pnz_hash: corner hash pipeline
// Three permutation lookups deep, one per register stage; yields the low
// four hash bits of all eight cell corners.
// ----------------------------------------------------------------------------
module pnz_hash (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  pnz_pkg::cell_type    cell_x,
   input  pnz_pkg::cell_type    cell_y,
   input  pnz_pkg::cell_type    cell_z,
   output logic                 out_valid,
   output pnz_pkg::hash_vec_type hash
);

   logic [2:0] valid_ff;

   pnz_pkg::cell_type a_ff, b_ff, cz1_ff;
   pnz_pkg::cell_type aa_ff, ab_ff, ba_ff, bb_ff;
   pnz_pkg::hash_vec_type hash_ff;

   // advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[1:0], in_valid};
      end
   end

   // Stage 1: row hashes; stage 2: column hashes; stage 3: corner hashes
   always_ff @(posedge clock) begin
      a_ff   <= pnz_pkg::perm(cell_x) + cell_y;
      b_ff   <= pnz_pkg::perm(cell_x + 8'd1) + cell_y;
      cz1_ff <= cell_z;

      aa_ff <= pnz_pkg::perm(a_ff) + cz1_ff;
      ab_ff <= pnz_pkg::perm(a_ff + 8'd1) + cz1_ff;
      ba_ff <= pnz_pkg::perm(b_ff) + cz1_ff;
      bb_ff <= pnz_pkg::perm(b_ff + 8'd1) + cz1_ff;

      // corner order: bit 0 selects x+1, bit 1 y+1, bit 2 z+1
      hash_ff[0] <= pnz_pkg::hash_type'(pnz_pkg::perm(aa_ff));
      hash_ff[1] <= pnz_pkg::hash_type'(pnz_pkg::perm(ba_ff));
      hash_ff[2] <= pnz_pkg::hash_type'(pnz_pkg::perm(ab_ff));
      hash_ff[3] <= pnz_pkg::hash_type'(pnz_pkg::perm(bb_ff));
      hash_ff[4] <= pnz_pkg::hash_type'(pnz_pkg::perm(aa_ff + 8'd1));
      hash_ff[5] <= pnz_pkg::hash_type'(pnz_pkg::perm(ba_ff + 8'd1));
      hash_ff[6] <= pnz_pkg::hash_type'(pnz_pkg::perm(ab_ff + 8'd1));
      hash_ff[7] <= pnz_pkg::hash_type'(pnz_pkg::perm(bb_ff + 8'd1));
   end

   assign out_valid = valid_ff[2];
   assign hash      = hash_ff;

endmodule

@@ rtl/pnz_blend.sv @@
// ----------------------------------------------------------------------------
// pnz_blend: gradient dot products, trilinear blend and output scaling
// Five register stages: gradients, x blend, y blend, z blend, output.
// ----------------------------------------------------------------------------
module pnz_blend #(
   parameter int FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  pnz_pkg::hash_vec_type       hash,
   input  logic [FRAC_BITS-1:0]        frac_x,
   input  logic [FRAC_BITS-1:0]        frac_y,
   input  logic [FRAC_BITS-1:0]        frac_z,
   input  logic signed [FRAC_BITS+4:0] fade_x,
   input  logic signed [FRAC_BITS+4:0] fade_y,
   input  logic signed [FRAC_BITS+4:0] fade_z,
   output logic                        out_valid,
   output logic [15:0]                 noise_value
);

   localparam int QW  = FRAC_BITS + 5;
   localparam int SHR = (FRAC_BITS >= 16) ? FRAC_BITS - 15 : 0;
   localparam int SHL = (FRAC_BITS < 16) ? 15 - FRAC_BITS : 0;
   localparam int RND = (FRAC_BITS >= 16) ? (1 << (FRAC_BITS - 16)) : 0;
   localparam int VW  = QW + 1 + SHL;
   localparam logic signed [QW-1:0]   Q_ONE  = QW'(1) <<< FRAC_BITS;
   localparam logic signed [2*QW-1:0] P_HALF = (2*QW)'(1) <<< (FRAC_BITS - 1);

   function automatic logic signed [QW-1:0] qmul(input logic signed [QW-1:0] a,
                                                 input logic signed [QW-1:0] b);
      logic signed [2*QW-1:0] p;
      p = a * b + P_HALF;
      return QW'(p >>> FRAC_BITS);
   endfunction

   function automatic logic signed [QW-1:0] lerp(input logic signed [QW-1:0] a,
                                                 input logic signed [QW-1:0] b,
                                                 input logic signed [QW-1:0] t);
      return a + qmul(t, b - a);
   endfunction

   logic [4:0] valid_ff;

   logic signed [QW-1:0] px0, py0, pz0, px1, py1, pz1;
   logic signed [QW-1:0] grad_in [pnz_pkg::CORNERS];
   logic signed [QW-1:0] grad_ff [pnz_pkg::CORNERS];
   logic signed [QW-1:0] lx_ff [4];
   logic signed [QW-1:0] ly_ff [2];
   logic signed [QW-1:0] lz_ff;
   logic signed [QW-1:0] u1_ff, v1_ff, w1_ff, v2_ff, w2_ff, w3_ff;
   logic signed [QW:0]   shifted;
   logic [VW-1:0]        scaled;
   logic [15:0]          noise_in, noise_ff;

   // advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[3:0], in_valid};
      end
   end

   // corner offsets: near side is the fraction, far side the fraction minus one
   assign px0 = QW'(frac_x);
   assign py0 = QW'(frac_y);
   assign pz0 = QW'(frac_z);
   assign px1 = px0 - Q_ONE;
   assign py1 = py0 - Q_ONE;
   assign pz1 = pz0 - Q_ONE;

   // pick the gradient terms from the hash of each corner
   always_comb begin
      for (int i = 0; i < pnz_pkg::CORNERS; i++) begin
         logic signed [QW-1:0] gx, gy, gz, gu, gv;
         pnz_pkg::hash_type h;
         h  = hash[i];
         gx = i[0] ? px1 : px0;
         gy = i[1] ? py1 : py0;
         gz = i[2] ? pz1 : pz0;
         // codes 0..7 use x, the rest y
         gu = h[3] ? gy : gx;
         // codes 0..3 use y, codes 12 and 14 use x, the rest z
         if (h[3:2] == 2'b00) begin
            gv = gy;
         end else if (h[3:2] == 2'b11 && !h[0]) begin
            gv = gx;
         end else begin
            gv = gz;
         end
         grad_in[i] = (h[0] ? -gu : gu) + (h[1] ? -gv : gv);
      end
   end

   // scale (noise + 1) / 2 to Q0.16 and saturate
   always_comb begin
      shifted = (QW+1)'(lz_ff) + (QW+1)'(Q_ONE);
      scaled  = ((VW'(shifted[QW-1:0]) + VW'(RND)) >> SHR) << SHL;
      if (shifted <= 0) begin
         noise_in = '0;
      end else if (scaled > VW'(pnz_pkg::OUT_MAX)) begin
         noise_in = pnz_pkg::OUT_MAX;
      end else begin
         noise_in = scaled[15:0];
      end
   end

   // blend pipeline
   always_ff @(posedge clock) begin
      for (int i = 0; i < pnz_pkg::CORNERS; i++) begin
         grad_ff[i] <= grad_in[i];
      end
      u1_ff <= fade_x;
      v1_ff <= fade_y;
      w1_ff <= fade_z;

      for (int j = 0; j < 4; j++) begin
         lx_ff[j] <= lerp(grad_ff[2*j], grad_ff[2*j+1], u1_ff);
      end
      v2_ff <= v1_ff;
      w2_ff <= w1_ff;

      ly_ff[0] <= lerp(lx_ff[0], lx_ff[1], v2_ff);
      ly_ff[1] <= lerp(lx_ff[2], lx_ff[3], v2_ff);
      w3_ff    <= w2_ff;

      lz_ff    <= lerp(ly_ff[0], ly_ff[1], w3_ff);

      noise_ff <= noise_in;
   end

   assign out_valid   = valid_ff[4];
   assign noise_value = noise_ff;

endmodule

@@ rtl/perlin_noise_3d.sv @@
// ----------------------------------------------------------------------------
// perlin_noise_3d: improved 3-D gradient noise, fixed point
// Point in, one noise sample out, fully pipelined.
// ----------------------------------------------------------------------------
// Usage: drive a point on req_point_x/y/z with start high; it is taken on any
// cycle busy is low, which is every cycle once reset is released, so one point
// per clock is sustained. The sample appears on rsp_noise_value with rsp_valid
// high for exactly one cycle, once the point has passed the input register,
// three stages of permutation lookup and fade products and five stages of
// gradient, blend and scaling. The receiver cannot stall: capture each
// result in the cycle it is strobed. Results leave in the order points entered.
// ----------------------------------------------------------------------------
module perlin_noise_3d #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_point_x,
   input  logic signed [31:0] req_point_y,
   input  logic signed [31:0] req_point_z,
   output logic               rsp_valid,
   output logic [15:0]        rsp_noise_value
);

   localparam int QW = FRAC_BITS + 5;

   logic        busy_ff;
   logic        valid_ff;
   logic [31:0] x_ff, y_ff, z_ff;

   logic [FRAC_BITS-1:0] fx_ff [3];
   logic [FRAC_BITS-1:0] fy_ff [3];
   logic [FRAC_BITS-1:0] fz_ff [3];

   logic signed [QW-1:0]  fade_x, fade_y, fade_z;
   logic                  hash_valid;
   pnz_pkg::hash_vec_type hash;

   // hold off transactions during reset
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b1;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= 1'b0;
         valid_ff <= start && !busy_ff;
      end
   end

   assign busy = busy_ff;

   // capture the point, delay the fractions alongside the hash stages
   always_ff @(posedge clock) begin
      x_ff <= req_point_x;
      y_ff <= req_point_y;
      z_ff <= req_point_z;
      fx_ff[0] <= x_ff[FRAC_BITS-1:0];
      fy_ff[0] <= y_ff[FRAC_BITS-1:0];
      fz_ff[0] <= z_ff[FRAC_BITS-1:0];
      for (int i = 1; i < 3; i++) begin
         fx_ff[i] <= fx_ff[i-1];
         fy_ff[i] <= fy_ff[i-1];
         fz_ff[i] <= fz_ff[i-1];
      end
   end

   pnz_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_x (
      .clock(clock), .frac(x_ff[FRAC_BITS-1:0]), .fade(fade_x)
   );
   pnz_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_y (
      .clock(clock), .frac(y_ff[FRAC_BITS-1:0]), .fade(fade_y)
   );
   pnz_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_z (
      .clock(clock), .frac(z_ff[FRAC_BITS-1:0]), .fade(fade_z)
   );

   pnz_hash u_hash (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (valid_ff),
      .cell_x    (x_ff[FRAC_BITS +: pnz_pkg::CELL_BITS]),
      .cell_y    (y_ff[FRAC_BITS +: pnz_pkg::CELL_BITS]),
      .cell_z    (z_ff[FRAC_BITS +: pnz_pkg::CELL_BITS]),
      .out_valid (hash_valid),
      .hash      (hash)
   );

   pnz_blend #(.FRAC_BITS(FRAC_BITS)) u_blend (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (hash_valid),
      .hash        (hash),
      .frac_x      (fx_ff[2]),
      .frac_y      (fy_ff[2]),
      .frac_z      (fz_ff[2]),
      .fade_x      (fade_x),
      .fade_y      (fade_y),
      .fade_z      (fade_z),
      .out_valid   (rsp_valid),
      .noise_value (rsp_noise_value)
   );

endmodule

@@ rtl/pnz_checker.sv @@
// ----------------------------------------------------------------------------
// pnz_checker: port-level checks for the noise pipeline
// Fixed latency in both directions and busy behavior around reset.
// ----------------------------------------------------------------------------
module pnz_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid
);

   // every accepted transaction produces a result after the fixed latency
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##(pnz_pkg::PIPE_LATENCY) rsp_valid)
      else $error("accepted transaction produced no result");

   // no result appears without a matching transaction
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, pnz_pkg::PIPE_LATENCY))
      else $error("result without an accepted transaction");

   // busy drops only on leaving reset: its register clears at the first
   // edge that sees reset low
   assert property (@(posedge clock)
      $fell(busy) |-> $past(reset, 2))
      else $error("busy dropped outside reset release");

endmodule

bind perlin_noise_3d pnz_checker u_pnz_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid)
);
